[hdl/twcs_pkg.sv]
// ----------------------------------------------------------------------------
// twcs_pkg
// Shared codes and controller/datapath link types for the wall column shader.
// ----------------------------------------------------------------------------
package twcs_pkg;

  // input word command codes
  localparam logic [1:0] CMD_WRITE_TEXEL = 2'd0;
  localparam logic [1:0] CMD_BEGIN_COL   = 2'd1;
  localparam logic [1:0] CMD_NEXT_PIXEL  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd0;
  localparam logic [1:0] REG_MID_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_CEILING_COLOR = 2'd2;
  localparam logic [1:0] REG_FLOOR_COLOR   = 2'd3;

  // reset values of the configuration registers
  localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd480;
  localparam logic [9:0]  MID_HEIGHT_RST    = 10'd240;

  // texture store geometry, fixed by the texel address field
  localparam int unsigned STORE_AW = 12;

  // controller -> datapath commands
  typedef struct packed {
    logic wr_texel;   // write the texel of the accepted word
    logic begin_col;  // latch slice, spans and divider operands
    logic div_step;   // one quotient bit
    logic mul_load;   // load step and start position
    logic pix_start;  // latch the reciprocal product for row mod TILE
    logic pix_mod;    // correct the texture row
    logic pix_read;   // read the texel
    logic pix_out;    // shade and offer the pixel
  } twcs_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic column_active;
    logic div_last;
    logic out_free;
  } twcs_sts_t;

endpackage

[hdl/twcs_ctrl.sv]
// ----------------------------------------------------------------------------
// twcs_ctrl
// Sequencer for texel writes, column setup and pixel shading.
// ----------------------------------------------------------------------------
module twcs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  twcs_pkg::twcs_sts_t sts,
  output twcs_pkg::twcs_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_PMOD  = 6'b001000,
    ST_PREAD = 6'b010000,
    ST_POUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_command)
            twcs_pkg::CMD_WRITE_TEXEL: begin
              cmd.wr_texel = 1'b1;
            end
            twcs_pkg::CMD_BEGIN_COL: begin
              cmd.begin_col = 1'b1;
              state_nxt     = ST_DIV;
            end
            twcs_pkg::CMD_NEXT_PIXEL: begin
              // drop the pixel when no column is open
              if (sts.column_active) begin
                cmd.pix_start = 1'b1;
                state_nxt     = ST_PMOD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_PMOD: begin
        cmd.pix_mod = 1'b1;
        state_nxt   = ST_PREAD;
      end
      ST_PREAD: begin
        cmd.pix_read = 1'b1;
        state_nxt    = ST_POUT;
      end
      ST_POUT: begin
        cmd.pix_out = 1'b1;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/twcs_datapath.sv]
// ----------------------------------------------------------------------------
// twcs_datapath
// Config registers, texture store, step divider, span logic and output word.
// ----------------------------------------------------------------------------
module twcs_datapath #(
  parameter int TILE     = 64,
  parameter int MAX_ROWS = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [11:0]         in_texel_index,
  input  logic [31:0]         in_texel_value,
  input  logic [15:0]         in_slice_height,
  input  logic [5:0]          in_texture_column,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [9:0]          out_row,
  output logic [31:0]         out_color,
  output logic                out_is_last,
  input  twcs_pkg::twcs_cmd_t cmd,
  output twcs_pkg::twcs_sts_t sts
);

  localparam int unsigned DIVIDEND = TILE * 65536;
  localparam int NUM_W  = $clog2(TILE + 1) + 16;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int TY_W   = $clog2(TILE);
  localparam int RECIP  = (1 << 24) / TILE;
  localparam int SCR_W  = 13;
  localparam int STORE_DEPTH = 1 << twcs_pkg::STORE_AW;

  // configuration
  logic [10:0] screen_r;
  logic [9:0]  mid_r;
  logic [31:0] ceil_r;
  logic [31:0] floor_r;

  // column state
  logic [10:0]      row_r;
  logic             active_r;
  logic [9:0]       start_r;
  logic [10:0]      end_r;
  logic [31:0]      pos_r;
  logic [31:0]      step_r;
  logic [5:0]       col_r;
  logic [14:0]      offset_r;

  // divider
  logic [NUM_W-1:0] dv_r;
  logic [15:0]      rem_r;
  logic [15:0]      div_h_r;
  logic [CNT_W-1:0] div_cnt_r;

  // pixel pipeline
  logic [13:0]      q_r;
  logic [TY_W-1:0]  ty_r;
  logic [31:0]      rdata_r;

  logic [31:0] store [STORE_DEPTH];

  // output word
  logic        out_valid_r, out_valid_nxt;
  logic [9:0]  out_row_r;
  logic [31:0] out_color_r;
  logic        out_last_r;

  // begin-column arithmetic
  logic [15:0] h_eff;
  logic [14:0] half;
  logic [15:0] reach;
  logic [SCR_W-1:0] scr_eff;
  logic [SCR_W-1:0] scr_m1;

  // divider step
  logic [17:0] trial;
  logic        ge;

  // pixel arithmetic
  logic [37:0] recip_prod;
  logic [16:0] rmod;
  logic [16:0] rmod_fix;
  logic [19:0] addr_full;
  logic [twcs_pkg::STORE_AW-1:0] rd_addr;
  logic [31:0] pos_prod;
  logic        in_floor, in_ceil, is_last, out_load;
  logic [31:0] color;

  always_comb begin
    h_eff = (in_slice_height == 16'd0) ? 16'd1 : in_slice_height;
    half  = h_eff[15:1];
    reach = 16'(mid_r) + 16'(half);
    if (screen_r == 11'd0) begin
      scr_eff = SCR_W'(1);
    end else if (SCR_W'(screen_r) > SCR_W'(MAX_ROWS)) begin
      scr_eff = SCR_W'(MAX_ROWS);
    end else begin
      scr_eff = SCR_W'(screen_r);
    end
    scr_m1 = scr_eff - SCR_W'(1);
  end

  // restoring division: shift one dividend bit into the partial remainder
  assign trial = {1'b0, rem_r, dv_r[NUM_W-1]} - {2'b00, div_h_r};
  assign ge    = !trial[17];

  assign pos_prod = 32'(offset_r) * 32'(dv_r);

  // row mod TILE through a truncated reciprocal, off by at most one TILE
  assign recip_prod = 38'(pos_r[31:16]) * 38'(RECIP);
  assign rmod       = 17'(pos_r[31:16]) - 17'(q_r) * 17'(TILE);
  assign rmod_fix   = (rmod >= 17'(TILE)) ? (rmod - 17'(TILE)) : rmod;
  assign addr_full  = 20'(TILE) * 20'(ty_r) + 20'(col_r);
  assign rd_addr    = addr_full[twcs_pkg::STORE_AW-1:0];

  always_comb begin
    in_floor = (row_r >= end_r);
    in_ceil  = (row_r < 11'(start_r));
    if (in_floor) begin
      color = floor_r;
    end else if (in_ceil) begin
      color = ceil_r;
    end else begin
      color = rdata_r;
    end
    is_last = (SCR_W'(row_r) >= scr_m1);
  end

  assign out_load      = cmd.pix_out && sts.out_free;
  assign out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);

  assign sts.column_active = active_r;
  assign sts.div_last      = (div_cnt_r == CNT_W'(NUM_W - 1));
  assign sts.out_free      = !out_valid_r || !out_stall;

  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_color   = out_color_r;
  assign out_is_last = out_last_r;

  // texture store
  always_ff @(posedge clk) begin
    if (cmd.wr_texel) begin
      store[in_texel_index] <= in_texel_value;
    end
    if (cmd.pix_read) begin
      rdata_r <= store[rd_addr];
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_r <= twcs_pkg::SCREEN_HEIGHT_RST;
      mid_r    <= twcs_pkg::MID_HEIGHT_RST;
      ceil_r   <= '0;
      floor_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        twcs_pkg::REG_SCREEN_HEIGHT: screen_r <= cfg_data[10:0];
        twcs_pkg::REG_MID_HEIGHT:    mid_r    <= cfg_data[9:0];
        twcs_pkg::REG_CEILING_COLOR: ceil_r   <= cfg_data;
        twcs_pkg::REG_FLOOR_COLOR:   floor_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // column state and divider
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      active_r  <= 1'b0;
      start_r   <= '0;
      end_r     <= '0;
      pos_r     <= '0;
      step_r    <= '0;
      col_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      if (cmd.begin_col) begin
        start_r   <= (16'(mid_r) >= 16'(half)) ? 10'(16'(mid_r) - 16'(half)) : 10'd0;
        offset_r  <= (16'(mid_r) >= 16'(half)) ? 15'd0 : 15'(16'(half) - 16'(mid_r));
        end_r     <= (16'(reach) > 16'(scr_m1)) ? 11'(scr_m1) : 11'(reach);
        col_r     <= in_texture_column;
        row_r     <= '0;
        active_r  <= 1'b1;
        dv_r      <= NUM_W'(DIVIDEND);
        rem_r     <= '0;
        div_h_r   <= h_eff;
        div_cnt_r <= '0;
      end
      if (cmd.div_step) begin
        rem_r     <= ge ? trial[15:0] : {rem_r[14:0], dv_r[NUM_W-1]};
        dv_r      <= {dv_r[NUM_W-2:0], ge};
        div_cnt_r <= div_cnt_r + CNT_W'(1);
      end
      if (cmd.mul_load) begin
        step_r <= 32'(dv_r);
        pos_r  <= pos_prod;
      end
      if (out_load) begin
        if (!in_floor && !in_ceil) begin
          pos_r <= pos_r + step_r;
        end
        if (is_last) begin
          active_r <= 1'b0;
        end else begin
          row_r <= row_r + 11'd1;
        end
      end
    end
  end

  // pixel pipeline and output word
  always_ff @(posedge clk) begin
    if (cmd.pix_start) begin
      q_r <= recip_prod[37:24];
    end
    if (cmd.pix_mod) begin
      ty_r <= rmod_fix[TY_W-1:0];
    end
    if (out_load) begin
      out_row_r   <= row_r[9:0];
      out_color_r <= color;
      out_last_r  <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pix_mod |=> (32'(ty_r) < 32'(TILE)))
    else $error("texture row out of range after correction");

  a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_load |=> (step_r != 32'd0))
    else $error("texture step is zero after column setup");

  a_pixel_needs_column: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pix_start |-> active_r)
    else $error("pixel started with no open column");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && is_last && !cmd.begin_col) |=> !active_r)
    else $error("column still open after its last pixel");

endmodule

[hdl/textured_wall_column_shader.sv]
// ----------------------------------------------------------------------------
// textured_wall_column_shader
// Shades one raycaster screen column from a TILE x TILE texture store.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in_     | input     | in_valid/in_stall  | command, texel_index, texel_value,
//          |           |                    | slice_height, texture_column
//  out_    | output    | out_valid/out_stall| row, color, is_last
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Write texel and ignored words, and a pixel with no open column, leave the
//  controller idle. Begin column latches the slice, then runs the restoring
//  divider that yields one bit of TILE*65536/height per cycle, then the
//  start-position multiply. Next pixel steps through the reciprocal multiply,
//  mod correction, texel read from the single-port store and shade into the
//  output register.
//  Reset (rst_n low, synchronous) closes the column and restores the configuration registers;
//  the texture store is not cleared. out_stall holds the output word and only
//  delays the next pixel once it is ready; cfg_ready is always high.
//
module textured_wall_column_shader #(
  parameter int TILE     = 64,
  parameter int MAX_ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [11:0] in_texel_index,
  input  logic [31:0] in_texel_value,
  input  logic [15:0] in_slice_height,
  input  logic [5:0]  in_texture_column,
  // pixel words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_row,
  output logic [31:0] out_color,
  output logic        out_is_last
);

  twcs_pkg::twcs_cmd_t cmd;
  twcs_pkg::twcs_sts_t sts;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  twcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd)
  );

  twcs_datapath #(
    .TILE     (TILE),
    .MAX_ROWS (MAX_ROWS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_texel_index    (in_texel_index),
    .in_texel_value    (in_texel_value),
    .in_slice_height   (in_slice_height),
    .in_texture_column (in_texture_column),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row           (out_row),
    .out_color         (out_color),
    .out_is_last       (out_is_last),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
